[rtl/sru_pkg.sv]
// Shared types and constants for the sum-up rounding block.
package sru_pkg;

    // Field widths fixed by the stream format.
    localparam int FRAC_W          = 17;
    localparam int DEF_W           = 24;
    localparam int NUM_FRAC_FIELDS = 8;
    localparam int CHOSEN_W        = 3;
    localparam int CNT_W           = 4;
    localparam int IDX_EXT_W       = 4;
    localparam int S_TDATA_W       = 136;
    localparam int M_TDATA_W       = 8;
    localparam int M_TUSER_W       = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_VANISH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd2;

    localparam logic [CNT_W-1:0] ACTIVE_RESET = 4'd8;

    // Per-lane status handed to the top level.
    typedef struct packed {
        logic elig;
        logic clip_add;
        logic clip_dec;
    } lane_stat_t;

    // One result item.
    typedef struct packed {
        logic [CHOSEN_W-1:0] chosen;
        logic                none_elig;
        logic                saturated;
    } result_t;

endpackage

[rtl/sru_lane.sv]
// One control lane: adds the fraction to its deficit, saturates, and checks eligibility.
module sru_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic signed [sru_pkg::DEF_W-1:0]  deficit,
    input  logic [sru_pkg::FRAC_W-1:0]        frac,
    input  logic                              start,
    input  logic                              active,
    input  logic                              vanish,
    input  logic [sru_pkg::FRAC_W-1:0]        tol,
    output logic signed [sru_pkg::DEF_W-1:0]  sum,
    output logic signed [sru_pkg::DEF_W-1:0]  dec,
    output sru_pkg::lane_stat_t               stat
);

    localparam int WW = sru_pkg::DEF_W + 2;
    localparam logic signed [WW-1:0] DMAX = WW'((64'sd1 <<< (sru_pkg::DEF_W - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] DMIN = WW'(-(64'sd1 <<< (sru_pkg::DEF_W - 1)));
    localparam logic signed [WW-1:0] ONE  = WW'(64'sd1 <<< FRAC_BITS);

    logic signed [sru_pkg::DEF_W-1:0] base;
    logic signed [WW-1:0]             add_wide;
    logic signed [WW-1:0]             dec_wide;
    logic                             add_hi;

    // A start request clears the deficit before the add.
    assign base = start ? '0 : deficit;

    // Add with saturation; the fraction is never negative, so only the top can clip.
    assign add_wide = WW'(base) + $signed({{(WW - sru_pkg::FRAC_W){1'b0}}, frac});
    assign add_hi   = active && (add_wide > DMAX);
    assign sum      = !active ? base :
                      (add_hi ? sru_pkg::DEF_W'(DMAX) : sru_pkg::DEF_W'(add_wide));

    // Take one whole unit off, saturating at the bottom.
    assign dec_wide = WW'(sum) - ONE;
    assign dec      = (dec_wide < DMIN) ? sru_pkg::DEF_W'(DMIN) : sru_pkg::DEF_W'(dec_wide);

    // Status toward the merge and the result.
    assign stat.clip_add = add_hi;
    assign stat.clip_dec = dec_wide < DMIN;
    assign stat.elig     = active && !(vanish && (frac <= tol));

endmodule

[rtl/sru_argmax.sv]
// Merge stage: balanced compare tree that finds the eligible lane with the largest deficit.
module sru_argmax #(
    parameter int NUM_CONTROLS = 8
) (
    input  logic signed [sru_pkg::DEF_W-1:0] sum [NUM_CONTROLS],
    input  logic [NUM_CONTROLS-1:0]          elig,
    output logic                             found,
    output logic [$clog2(NUM_CONTROLS)-1:0]  pick
);

    localparam int IDX_W = $clog2(NUM_CONTROLS);
    localparam int LVLS  = IDX_W;
    localparam int P     = 1 << LVLS;

    logic                       node_v [LVLS+1][P];
    logic signed [sru_pkg::DEF_W-1:0] node_d [LVLS+1][P];
    logic [IDX_W-1:0]           node_i [LVLS+1][P];

    // Each node keeps an eligible left child unless the right one is eligible and strictly
    // larger, so ties go to the lower index.
    always_comb begin
        for (int lv = 0; lv <= LVLS; lv++) begin
            for (int k = 0; k < P; k++) begin
                node_v[lv][k] = 1'b0;
                node_d[lv][k] = '0;
                node_i[lv][k] = '0;
            end
        end
        for (int k = 0; k < NUM_CONTROLS; k++) begin
            node_v[0][k] = elig[k];
            node_d[0][k] = sum[k];
            node_i[0][k] = IDX_W'(k);
        end
        for (int lv = 0; lv < LVLS; lv++) begin
            for (int k = 0; k < P / 2; k++) begin
                if (node_v[lv][2*k] &&
                    (!node_v[lv][2*k+1] || node_d[lv][2*k] >= node_d[lv][2*k+1])) begin
                    node_v[lv+1][k] = 1'b1;
                    node_d[lv+1][k] = node_d[lv][2*k];
                    node_i[lv+1][k] = node_i[lv][2*k];
                end else begin
                    node_v[lv+1][k] = node_v[lv][2*k+1];
                    node_d[lv+1][k] = node_d[lv][2*k+1];
                    node_i[lv+1][k] = node_i[lv][2*k+1];
                end
            end
        end
    end

    assign found = node_v[LVLS][0];
    assign pick  = node_i[LVLS][0];

endmodule

[rtl/sum_up_rounding.sv]
// A result is registered into the output entry, or into the skid entry when the output is held.
// Throughput: one request per cycle while the skid entry is empty; the deficit update
// (add, compare tree, decrement) is combinational over the registered deficits.
// A two-entry output stage accepts one more request while a result waits.
// Reset (aresetn low, synchronous) clears deficits and both output entries,
// and sets vanishing_mode 0, zero_tolerance 0, active_count 8.
module sum_up_rounding #(
    parameter int NUM_CONTROLS = 8,
    parameter int FRAC_BITS    = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration writes.
    input  logic                              cfg_wr_en,
    input  logic [sru_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sru_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sru_pkg::S_TDATA_W-1:0]     s_tdata,   // frac_0 .. frac_7, 17 bits each
    input  logic                              s_tuser,   // start_req
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sru_pkg::M_TDATA_W-1:0]     m_tdata,   // chosen [2:0], zero pad
    output logic [sru_pkg::M_TUSER_W-1:0]     m_tuser    // none_eligible [0], saturated [1]
);

    localparam int IDX_W = $clog2(NUM_CONTROLS);
    localparam logic [sru_pkg::CNT_W-1:0] NC = sru_pkg::CNT_W'(NUM_CONTROLS);

    // Configuration registers.
    logic                          vanish_reg;
    logic [sru_pkg::FRAC_W-1:0]    tol_reg;
    logic [sru_pkg::CNT_W-1:0]     active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vanish_reg <= 1'b0;
            tol_reg    <= '0;
            active_reg <= sru_pkg::ACTIVE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sru_pkg::REG_VANISH: vanish_reg <= cfg_data[0];
                sru_pkg::REG_TOL:    tol_reg    <= cfg_data;
                sru_pkg::REG_ACTIVE: active_reg <= cfg_data[sru_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective lane count, held to the range one to NUM_CONTROLS.
    logic [sru_pkg::CNT_W-1:0] lanes_eff;
    assign lanes_eff = (active_reg == '0) ? sru_pkg::CNT_W'(1) :
                       ((active_reg > NC) ? NC : active_reg);

    logic push;
    logic pop;
    assign push = s_tvalid && s_tready;
    assign pop  = m_tvalid && m_tready;

    // Lanes.
    logic signed [sru_pkg::DEF_W-1:0] deficit_reg [NUM_CONTROLS];
    logic signed [sru_pkg::DEF_W-1:0] deficit_next [NUM_CONTROLS];
    logic signed [sru_pkg::DEF_W-1:0] lane_sum [NUM_CONTROLS];
    logic signed [sru_pkg::DEF_W-1:0] lane_dec [NUM_CONTROLS];
    sru_pkg::lane_stat_t              lane_stat [NUM_CONTROLS];
    logic [NUM_CONTROLS-1:0]          lane_elig;

    for (genvar g = 0; g < NUM_CONTROLS; g++) begin : g_lane
        logic [sru_pkg::FRAC_W-1:0] frac;
        if (g < sru_pkg::NUM_FRAC_FIELDS) begin : g_field
            assign frac = s_tdata[g*sru_pkg::FRAC_W +: sru_pkg::FRAC_W];
        end else begin : g_nofield
            assign frac = '0;
        end

        sru_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .deficit(deficit_reg[g]),
            .frac   (frac),
            .start  (s_tuser),
            .active (sru_pkg::CNT_W'(g) < lanes_eff),
            .vanish (vanish_reg),
            .tol    (tol_reg),
            .sum    (lane_sum[g]),
            .dec    (lane_dec[g]),
            .stat   (lane_stat[g])
        );

        assign lane_elig[g] = lane_stat[g].elig;
    end

    // Merge: pick the largest eligible deficit.
    logic             found;
    logic [IDX_W-1:0] pick;

    sru_argmax #(
        .NUM_CONTROLS(NUM_CONTROLS)
    ) u_argmax (
        .sum  (lane_sum),
        .elig (lane_elig),
        .found(found),
        .pick (pick)
    );

    // Next deficits and the result of this step.
    sru_pkg::result_t  res;
    logic [sru_pkg::IDX_EXT_W-1:0] pick_ext;
    logic              any_clip;

    assign pick_ext = sru_pkg::IDX_EXT_W'(pick);

    always_comb begin
        any_clip = 1'b0;
        for (int i = 0; i < NUM_CONTROLS; i++) begin
            if (found && pick == IDX_W'(i)) begin
                deficit_next[i] = lane_dec[i];
                any_clip        = any_clip | lane_stat[i].clip_dec;
            end else begin
                deficit_next[i] = lane_sum[i];
            end
            any_clip = any_clip | lane_stat[i].clip_add;
        end
        res.chosen    = found ? pick_ext[sru_pkg::CHOSEN_W-1:0] : '0;
        res.none_elig = !found;
        res.saturated = any_clip;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CONTROLS; i++) begin
                deficit_reg[i] <= '0;
            end
        end else if (push) begin
            for (int i = 0; i < NUM_CONTROLS; i++) begin
                deficit_reg[i] <= deficit_next[i];
            end
        end
    end

    // Output register plus skid entry.
    logic              out_valid_reg;
    logic              skid_valid_reg;
    sru_pkg::result_t  out_reg;
    sru_pkg::result_t  skid_reg;

    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        if (out_valid_reg && !pop && push) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sru_pkg::M_TDATA_W'(out_reg.chosen);
    assign m_tuser  = {out_reg.saturated, out_reg.none_elig};

    // A result without an eligible lane always reports lane zero.
    a_none_chosen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[sru_pkg::CHOSEN_W-1:0] == '0)
        else $error("none_eligible result with nonzero chosen");

    // The skid entry is only filled behind a held output entry.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output entry empty");

    // Without vanishing mode, lane zero is always eligible.
    a_found_no_vanish: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !vanish_reg |-> found)
        else $error("no eligible lane with vanishing mode off");

    // While both output entries are full and nothing is popped, both stay full.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && skid_valid_reg && !pop |=> skid_valid_reg && out_valid_reg)
        else $error("output entries lost a result");

endmodule
